>>> src/oll_pkg.sv
// ----------------------------------------------------------------------------
// oll_pkg
// Shared types and constants for the ordered list block.
// ----------------------------------------------------------------------------
package oll_pkg;

    localparam int CAPACITY_DEF    = 256;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int CMD_W           = 3;
    localparam int STATUS_W        = 2;
    localparam int COUNT_W         = 9;
    localparam int FIELD_W         = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_INS_HEAD = 3'd0,
        CMD_INS_MID  = 3'd1,
        CMD_INS_TAIL = 3'd2,
        CMD_DEL_HEAD = 3'd3,
        CMD_DEL_TAIL = 3'd4,
        CMD_DEL_VAL  = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,      // capture request, start head read
        OP_WALK,      // step cursor to next link
        OP_CMP,       // compare cursor value
        OP_ALLOC,     // pop free slot into new slot register
        OP_LINK_HEAD,
        OP_LINK_TAIL,
        OP_LINK_MID,
        OP_UNLINK,
        OP_FIX,       // second link write for middle insert
        OP_HT_READ,   // read head and tail values
        OP_HT_CAP
    } op_t;

    typedef struct packed {
        op_t  op;
        logic sel_tail;   // unlink target is tail, else cursor
        logic sel_head;   // unlink target is head
    } ctl_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic steps_done;
        logic match;
        logic last;       // cursor reached the tail
    } sts_t;

endpackage

>>> src/oll_datapath.sv
// ----------------------------------------------------------------------------
// oll_datapath
// Slot stores, link memories, free stack and list pointers.
// ----------------------------------------------------------------------------
module oll_datapath #(
    parameter int CAPACITY    = oll_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = oll_pkg::VALUE_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  oll_pkg::ctl_t                ctl,
    input  logic [oll_pkg::CMD_W-1:0]    in_cmd,
    input  logic [oll_pkg::FIELD_W-1:0]  in_value,
    output oll_pkg::sts_t                sts,
    output logic [$clog2(CAPACITY+1)-1:0] count_out,
    output logic [oll_pkg::FIELD_W-1:0]  head_out,
    output logic [oll_pkg::FIELD_W-1:0]  tail_out
);
    localparam int SW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY+1);

    logic [VALUE_WIDTH-1:0] mem_val  [CAPACITY];
    logic [SW-1:0]          mem_next [CAPACITY];
    logic [SW-1:0]          mem_prev [CAPACITY];
    logic [SW-1:0]          mem_free [CAPACITY];

    logic [SW-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] fill_reg;   // peak element count since reset
    logic [SW-1:0] cur_reg, new_reg, rn_reg, rp_reg;
    logic [CW-1:0] step_reg;
    logic [VALUE_WIDTH-1:0] val_reg, rd_val_reg, hv_reg, tv_reg;
    logic [SW-1:0] free_top_reg;
    logic [CW-1:0] nfree;
    logic [SW-1:0] tgt;
    logic [SW-1:0] rd_addr;
    logic [VALUE_WIDTH-1:0] vmask;

    assign nfree   = CW'(CAPACITY) - count_reg;
    assign vmask   = VALUE_WIDTH'(signed'(in_value));
    assign tgt     = ctl.sel_head ? head_reg : (ctl.sel_tail ? tail_reg : cur_reg);
    assign rd_addr = (ctl.op == oll_pkg::OP_HT_READ) ? head_reg : tgt;

    assign sts.empty      = (count_reg == '0);
    assign sts.full       = (count_reg == CW'(CAPACITY));
    assign sts.steps_done = (step_reg == '0);
    assign sts.match      = (rd_val_reg == val_reg);
    assign sts.last       = (cur_reg == tail_reg);

    // Free stack: slots from the high-water mark up pop in index order.
    always_ff @(posedge aclk) begin
        if (count_reg >= fill_reg) begin
            free_top_reg <= SW'(count_reg);
        end else begin
            free_top_reg <= mem_free[SW'(nfree - 1'b1)];
        end
        rd_val_reg <= mem_val[rd_addr];
        if (ctl.op == oll_pkg::OP_HT_READ) hv_reg <= mem_val[rd_addr];
        rn_reg     <= mem_next[tgt];
        rp_reg     <= mem_prev[tgt];
        tv_reg     <= mem_val[tail_reg];
    end

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        unique case (ctl.op)
            oll_pkg::OP_LINK_HEAD: begin
                head_next  = new_reg;
                if (count_reg == '0) tail_next = new_reg;
                count_next = count_reg + 1'b1;
            end
            oll_pkg::OP_LINK_TAIL: begin
                tail_next  = new_reg;
                if (count_reg == '0) head_next = new_reg;
                count_next = count_reg + 1'b1;
            end
            oll_pkg::OP_LINK_MID: begin
                if (cur_reg == tail_reg) tail_next = new_reg;
                count_next = count_reg + 1'b1;
            end
            oll_pkg::OP_UNLINK: begin
                if (tgt == head_reg) head_next = rn_reg;
                if (tgt == tail_reg) tail_next = rp_reg;
                count_next = count_reg - 1'b1;
                if (count_reg == CW'(1)) begin
                    head_next = '0;
                    tail_next = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            fill_reg  <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            if (count_next > fill_reg) begin
                fill_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (ctl.op)
            oll_pkg::OP_LOAD: begin
                val_reg  <= vmask;
                cur_reg  <= head_reg;
                step_reg <= (count_reg - 1'b1) >> 1;
            end
            oll_pkg::OP_WALK: begin
                cur_reg  <= rn_reg;
                step_reg <= step_reg - 1'b1;
            end
            oll_pkg::OP_ALLOC: new_reg <= free_top_reg;
            oll_pkg::OP_LINK_HEAD: begin
                mem_val[new_reg] <= val_reg;
                if (count_reg != '0) begin
                    mem_next[new_reg]  <= head_reg;
                    mem_prev[head_reg] <= new_reg;
                end
            end
            oll_pkg::OP_LINK_TAIL: begin
                mem_val[new_reg] <= val_reg;
                if (count_reg != '0) begin
                    mem_prev[new_reg]  <= tail_reg;
                    mem_next[tail_reg] <= new_reg;
                end
            end
            oll_pkg::OP_LINK_MID: begin
                mem_val[new_reg]  <= val_reg;
                mem_prev[new_reg] <= cur_reg;
                mem_next[cur_reg] <= new_reg;
                if (cur_reg != tail_reg) begin
                    mem_next[new_reg] <= rn_reg;
                end
            end
            oll_pkg::OP_FIX: begin
                mem_prev[rn_reg] <= new_reg;
            end
            oll_pkg::OP_UNLINK: begin
                mem_free[SW'(nfree)] <= tgt;
                if (tgt != head_reg) mem_next[rp_reg] <= rn_reg;
                if (tgt != tail_reg) mem_prev[rn_reg] <= rp_reg;
                cur_reg <= rn_reg;
                new_reg <= rp_reg;
            end
            default: ;
        endcase
    end

    assign count_out = count_reg;
    assign head_out  = (count_reg == '0) ? '0 : oll_pkg::FIELD_W'(hv_reg);
    assign tail_out  = (count_reg == '0) ? '0 : oll_pkg::FIELD_W'(tv_reg);

    logic unused_cmd;
    assign unused_cmd = ^in_cmd;
endmodule

>>> src/oll_ctrl.sv
// ----------------------------------------------------------------------------
// oll_ctrl
// Sequencer for list requests and the result register.
// ----------------------------------------------------------------------------
module oll_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [oll_pkg::CMD_W-1:0]   s_cmd,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [oll_pkg::STATUS_W-1:0] status,
    input  oll_pkg::sts_t               sts,
    output oll_pkg::ctl_t               ctl
);
    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_DISP  = 12'b000000000010,
        S_WALK  = 12'b000000000100,
        S_WRD   = 12'b000000001000,
        S_ALLOC = 12'b000000010000,
        S_LINK  = 12'b000000100000,
        S_FIX   = 12'b000001000000,
        S_SRD   = 12'b000010000000,
        S_SCMP  = 12'b000100000000,
        S_UNL   = 12'b001000000000,
        S_HT    = 12'b010000000000,
        S_OUT   = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;
    logic [oll_pkg::CMD_W-1:0] cmd_reg, cmd_next;
    logic [oll_pkg::STATUS_W-1:0] st_reg, st_next;
    logic mid_fix_reg, mid_fix_next;
    logic ins;

    assign ins = (cmd_reg == oll_pkg::CMD_INS_HEAD) || (cmd_reg == oll_pkg::CMD_INS_MID)
              || (cmd_reg == oll_pkg::CMD_INS_TAIL);
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign status   = st_reg;

    always_comb begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        st_next      = st_reg;
        mid_fix_next = mid_fix_reg;
        ctl          = '{op: oll_pkg::OP_NONE, sel_tail: 1'b0, sel_head: 1'b0};
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd_next   = s_cmd;
                    st_next    = oll_pkg::ST_OK;
                    ctl.op     = oll_pkg::OP_LOAD;
                    ctl.sel_head = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                ctl.sel_head = 1'b1;
                if (ins) begin
                    if (sts.full) begin
                        st_next = oll_pkg::ST_FULL;
                        state_next = S_HT;
                    end else begin
                        state_next = (cmd_reg == oll_pkg::CMD_INS_MID && !sts.empty)
                                   ? S_WRD : S_ALLOC;
                    end
                end else if (cmd_reg == oll_pkg::CMD_DEL_HEAD
                          || cmd_reg == oll_pkg::CMD_DEL_TAIL
                          || cmd_reg == oll_pkg::CMD_DEL_VAL) begin
                    if (sts.empty) begin
                        st_next = oll_pkg::ST_EMPTY;
                        state_next = S_HT;
                    end else if (cmd_reg == oll_pkg::CMD_DEL_VAL) begin
                        state_next = S_SRD;
                    end else begin
                        state_next = S_SRD;
                    end
                end else begin
                    state_next = S_HT;
                end
            end
            S_WRD: state_next = sts.steps_done ? S_ALLOC : S_WALK;
            S_WALK: begin
                ctl.op = oll_pkg::OP_WALK;
                state_next = S_WRD;
            end
            S_ALLOC: begin
                ctl.op = oll_pkg::OP_ALLOC;
                state_next = S_LINK;
            end
            S_LINK: begin
                mid_fix_next = 1'b0;
                if (cmd_reg == oll_pkg::CMD_INS_HEAD || sts.empty) begin
                    ctl.op = oll_pkg::OP_LINK_HEAD;
                end else if (cmd_reg == oll_pkg::CMD_INS_TAIL) begin
                    ctl.op = oll_pkg::OP_LINK_TAIL;
                end else begin
                    ctl.op = oll_pkg::OP_LINK_MID;
                    mid_fix_next = !sts.last;
                end
                state_next = S_FIX;
            end
            S_FIX: begin
                if (mid_fix_reg) ctl.op = oll_pkg::OP_FIX;
                state_next = S_HT;
            end
            S_SRD: begin
                ctl.sel_head = (cmd_reg == oll_pkg::CMD_DEL_HEAD);
                ctl.sel_tail = (cmd_reg == oll_pkg::CMD_DEL_TAIL);
                state_next = (cmd_reg == oll_pkg::CMD_DEL_VAL) ? S_SCMP : S_UNL;
            end
            S_SCMP: begin
                if (sts.match) begin
                    state_next = S_UNL;
                end else if (sts.last) begin
                    st_next = oll_pkg::ST_NOT_FOUND;
                    state_next = S_HT;
                end else begin
                    ctl.op = oll_pkg::OP_WALK;
                    state_next = S_SRD;
                end
            end
            S_UNL: begin
                ctl.sel_head = (cmd_reg == oll_pkg::CMD_DEL_HEAD);
                ctl.sel_tail = (cmd_reg == oll_pkg::CMD_DEL_TAIL);
                ctl.op = oll_pkg::OP_UNLINK;
                state_next = S_HT;
            end
            S_HT: begin
                ctl.op = oll_pkg::OP_HT_READ;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (m_tready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cmd_reg     <= '0;
            st_reg      <= '0;
            mid_fix_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cmd_reg     <= cmd_next;
            st_reg      <= st_next;
            mid_fix_reg <= mid_fix_next;
        end
    end
endmodule

>>> src/ordered_list_with_middle_insert_top.sv
// ----------------------------------------------------------------------------
// ordered_list_with_middle_insert_top
// Doubly linked list of signed values with head, middle and tail insert.
// ----------------------------------------------------------------------------
// One request is handled at a time. A middle insert walks half the list and a
// delete by value walks up to the whole list; each step waits on a registered
// read of the link memory. The result is held on the m_ side until taken.
module ordered_list_with_middle_insert_top #(
    parameter int CAPACITY    = oll_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = oll_pkg::VALUE_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // cmd[2:0], item_value[34:3], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata    // status, element_count, head_value, tail_value
);
    oll_pkg::ctl_t ctl;
    oll_pkg::sts_t sts;
    logic [1:0]  status;
    logic [$clog2(CAPACITY+1)-1:0] cnt;
    logic [31:0] hv, tv;
    logic [4:0]  unused_pad;

    assign unused_pad = s_tdata[39:35];

    oll_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_cmd(s_tdata[2:0]),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .status(status),
        .sts(sts), .ctl(ctl)
    );

    oll_datapath #(.CAPACITY(CAPACITY), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .ctl(ctl),
        .in_cmd(s_tdata[2:0]), .in_value(s_tdata[34:3]),
        .sts(sts), .count_out(cnt), .head_out(hv), .tail_out(tv)
    );

    assign m_tdata = {5'd0, tv, hv, 9'(cnt), status};
endmodule

>>> src/oll_checker.sv
// ----------------------------------------------------------------------------
// oll_checker
// Port-level checks for the ordered list block.
// ----------------------------------------------------------------------------
module oll_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata
);
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("input taken while result pending");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[10:2] == 9'd0 |-> m_tdata[74:11] == 64'd0)
        else $error("empty list reports values");
    a_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[10:2] <= 9'd256) else $error("count over capacity");
    a_no_early: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !m_tvalid) else $error("result too early");
endmodule

bind ordered_list_with_middle_insert_top oll_checker u_oll_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
